>>> sv/hilbert_curve_2d_encode_decode_top_macros.svh
// assertion macros for the hilbert curve mapper checker
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef HILBERT_CURVE_2D_ENCODE_DECODE_TOP_MACROS_SVH
`define HILBERT_CURVE_2D_ENCODE_DECODE_TOP_MACROS_SVH

// antecedent and consequent in the same cycle
`define HCE_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("hce: same-cycle check failed");

// consequent in the cycle after the antecedent
`define HCE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("hce: next-cycle check failed");

`endif

>>> sv/hce_pkg.sv
// constants, types and per-level digit logic of the hilbert curve mapper
// no dependencies; used by the interfaces, the stage and the top level
package hce_pkg;

  localparam int COORD_BITS   = 32;
  localparam int COORD_W      = 32;
  localparam int KEY_W        = 64;
  localparam int CIDX_W       = 5;
  localparam int LVLS_PER_STG = 8;
  localparam int NUM_STG      = (COORD_BITS + LVLS_PER_STG - 1) / LVLS_PER_STG;
  localparam int LVL_W        = (COORD_BITS > 2) ? $clog2(COORD_BITS) : 1;

  typedef enum logic {
    CMD_ENCODE = 1'b0,
    CMD_DECODE = 1'b1
  } cmd_e;

  typedef struct packed {
    logic [1:0] w;
    logic [1:0] tt;
    logic       par;
  } lvl_state_t;

  typedef struct packed {
    logic [1:0] dig;
    lvl_state_t st;
  } lvl_res_t;

  typedef struct packed {
    cmd_e               cmd;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [KEY_W-1:0]   key;
    lvl_state_t         st;
  } pipe_rec_t;

  function automatic logic [1:0] rot2(input logic par, input logic [1:0] v);
    return par ? {v[0], v[1]} : v;
  endfunction

  function automatic logic [1:0] gray_to_bin(input logic [1:0] s);
    return {s[1], s[1] ^ s[0]};
  endfunction

  function automatic logic [1:0] bin_to_gray(input logic [1:0] p);
    return {p[1], p[1] ^ p[0]};
  endfunction

  // one bit level: encode maps point digit to key digit, decode the reverse
  function automatic lvl_res_t lvl_step(input cmd_e cmd, input logic [1:0] d,
                                        input lvl_state_t st);
    lvl_res_t   res;
    logic [1:0] w;
    logic [1:0] p;
    w = st.w ^ st.tt;
    if (cmd == CMD_ENCODE) begin
      p       = gray_to_bin(rot2(st.par, d ^ w));
      res.dig = p;
    end else begin
      p       = d;
      res.dig = w ^ rot2(st.par, bin_to_gray(p));
    end
    res.st.w   = w;
    res.st.tt  = (p == 2'b11) ? 2'b11 : 2'b00;
    res.st.par = st.par ^ (p[1] == p[0]);
    return res;
  endfunction

endpackage

>>> sv/hce_in_if.sv
// input channel of the hilbert curve mapper: valid/ready plus command and operands
// depends on hce_pkg
interface hce_in_if import hce_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               cmd;
  logic [COORD_W-1:0] coord_x;
  logic [COORD_W-1:0] coord_y;
  logic [KEY_W-1:0]   key_in;

  modport source (output valid, cmd, coord_x, coord_y, key_in, input ready);
  modport sink   (input valid, cmd, coord_x, coord_y, key_in, output ready);
endinterface

>>> sv/hce_out_if.sv
// output channel of the hilbert curve mapper: valid/ready plus key and point
// depends on hce_pkg
interface hce_out_if import hce_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [KEY_W-1:0]   key_out;
  logic [COORD_W-1:0] point_x;
  logic [COORD_W-1:0] point_y;

  modport source (output valid, key_out, point_x, point_y, input ready);
  modport sink   (input valid, key_out, point_x, point_y, output ready);
endinterface

>>> sv/hilbert_curve_2d_encode_decode_top.sv
// Hilbert curve mapper, 2-D, 32-bit coordinates to 64-bit key and back. cmd 0 encodes
// (coord_x, coord_y) into key_out, cmd 1 decodes key_in into (point_x, point_y); the
// fields not produced by the command read as zero. One beat is accepted per cycle while
// the output is not stalled; the 32 bit levels are walked from the top down in register
// stages of eight levels each, each stage carrying the reflection and rotation state to
// the next. A stalled output holds the pipeline in place; no beat is dropped or repeated.
// Items are independent of each other.
// depends on hce_pkg, hce_in_if, hce_out_if and hce_stage
module hilbert_curve_2d_encode_decode_top import hce_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  hce_in_if.sink    in_i,
  hce_out_if.source out_o
);

  logic      stg_valid [NUM_STG+1];
  logic      stg_ready [NUM_STG+1];
  pipe_rec_t stg_rec   [NUM_STG+1];
  pipe_rec_t last_rec;

  // entry: clear the fields the command will fill
  always_comb begin
    stg_rec[0].cmd = cmd_e'(in_i.cmd);
    stg_rec[0].st  = '0;
    if (cmd_e'(in_i.cmd) == CMD_ENCODE) begin
      stg_rec[0].x   = in_i.coord_x;
      stg_rec[0].y   = in_i.coord_y;
      stg_rec[0].key = '0;
    end else begin
      stg_rec[0].x   = '0;
      stg_rec[0].y   = '0;
      stg_rec[0].key = in_i.key_in;
    end
  end

  assign stg_valid[0] = in_i.valid;
  assign in_i.ready   = stg_ready[0];

  for (genvar s = 0; s < NUM_STG; s++) begin : g_stg
    localparam int Base = COORD_BITS - 1 - s * LVLS_PER_STG;
    hce_stage u_stage (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .lvl_base_i (LVL_W'(Base)),
      .valid_i    (stg_valid[s]),
      .rec_i      (stg_rec[s]),
      .ready_o    (stg_ready[s]),
      .valid_o    (stg_valid[s+1]),
      .rec_o      (stg_rec[s+1]),
      .ready_i    (stg_ready[s+1])
    );
  end

  assign stg_ready[NUM_STG] = out_o.ready;
  assign last_rec           = stg_rec[NUM_STG];

  assign out_o.valid   = stg_valid[NUM_STG];
  assign out_o.key_out = (last_rec.cmd == CMD_ENCODE) ? last_rec.key : '0;
  assign out_o.point_x = (last_rec.cmd == CMD_DECODE) ? last_rec.x : '0;
  assign out_o.point_y = (last_rec.cmd == CMD_DECODE) ? last_rec.y : '0;

endmodule

>>> sv/hce_stage.sv
// one pipeline stage: up to LVLS_PER_STG bit levels from lvl_base_i downward
// depends on hce_pkg
module hce_stage import hce_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [LVL_W-1:0] lvl_base_i,
  input  logic             valid_i,
  input  pipe_rec_t        rec_i,
  output logic             ready_o,
  output logic             valid_o,
  output pipe_rec_t        rec_o,
  input  logic             ready_i
);

  logic      valid_q, valid_d;
  pipe_rec_t rec_q, rec_d;
  logic      load;

  always_comb begin
    int              lb;
    logic [CIDX_W-1:0] ix;
    lvl_res_t        res;
    rec_d = rec_i;
    for (int j = 0; j < LVLS_PER_STG; j++) begin
      lb = int'(lvl_base_i) - j;
      ix = CIDX_W'(lb);
      res = '0;
      if (lb >= 0) begin
        if (rec_d.cmd == CMD_ENCODE) begin
          res = lvl_step(rec_d.cmd, {rec_d.x[ix], rec_d.y[ix]}, rec_d.st);
          rec_d.key[{ix, 1'b1}] = res.dig[1];
          rec_d.key[{ix, 1'b0}] = res.dig[0];
        end else begin
          res = lvl_step(rec_d.cmd, {rec_d.key[{ix, 1'b1}], rec_d.key[{ix, 1'b0}]},
                         rec_d.st);
          rec_d.x[ix] = res.dig[1];
          rec_d.y[ix] = res.dig[0];
        end
        rec_d.st = res.st;
      end
    end
  end

  // stage takes a beat when empty or when its own beat moves on
  assign ready_o = !valid_q || ready_i;
  assign load    = valid_i && ready_o;
  assign valid_d = ready_o ? valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      rec_q <= rec_d;
    end
  end

  assign valid_o = valid_q;
  assign rec_o   = rec_q;

endmodule

>>> sv/hce_checker.sv
// port-level checks on the hilbert curve mapper, bound to the top level
// depends on hce_pkg and the macros header
`include "hilbert_curve_2d_encode_decode_top_macros.svh"

module hce_checker import hce_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_ready_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input logic [KEY_W-1:0]   key_out_i,
  input logic [COORD_W-1:0] point_x_i,
  input logic [COORD_W-1:0] point_y_i
);

  logic [KEY_W+2*COORD_W-1:0] res_bits;

  assign res_bits = {key_out_i, point_x_i, point_y_i};

  // a waiting result holds still
  `HCE_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(res_bits))

  // a result carries either a key or a point, never both
  `HCE_ASSERT_SAME(a_one_result, out_valid_i, key_out_i == '0 || (point_x_i == '0 && point_y_i == '0))

  // input back-pressure only comes from a full pipeline stalled at the output
  `HCE_ASSERT_SAME(a_ready_cause, !in_ready_i, out_valid_i && !out_ready_i)

endmodule

bind hilbert_curve_2d_encode_decode_top hce_checker u_hce_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .key_out_i   (out_o.key_out),
  .point_x_i   (out_o.point_x),
  .point_y_i   (out_o.point_y)
);

>>> bench/hilbert_curve_2d_encode_decode_top_tb.sv
`timescale 1ns / 100ps
// testbench for the 2-d hilbert curve mapper: directed table then random encode/decode beats
// depends on hce_pkg, hce_in_if, hce_out_if and hilbert_curve_2d_encode_decode_top
module hilbert_curve_2d_encode_decode_top_tb;
  import hce_pkg::*;

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [COORD_W-1:0] px;
    logic [COORD_W-1:0] py;
  } map_res_t;

  typedef struct packed {
    cmd_e               op;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [KEY_W-1:0]   k;
    logic               fixed;
    map_res_t           res;
  } stim_row_t;

  localparam int NUM_RANDOM = 1200;
  localparam int TAIL_CYC   = 12;

  logic clk_i;
  logic rst_ni;

  hce_in_if  in_bus ();
  hce_out_if out_bus ();

  hilbert_curve_2d_encode_decode_top u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  map_res_t  pending_res[$];
  stim_row_t dir_rows[$];
  logic      cur_fixed;
  map_res_t  cur_res;
  bit        calm;
  int        mismatches;
  int        printed;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #2ms;
    $display("TB_ERROR");
    $finish;
  end

  // walks the bit levels from the top, carrying reflection and rotation parity
  function automatic map_res_t hilbert_map(input cmd_e op, input logic [COORD_W-1:0] x,
                                           input logic [COORD_W-1:0] y,
                                           input logic [KEY_W-1:0] k);
    map_res_t   r;
    logic [1:0] refl;
    logic [1:0] flip;
    logic [1:0] a;
    logic [1:0] s;
    logic [1:0] p;
    logic       turn;
    r    = '0;
    refl = 2'b00;
    flip = 2'b00;
    turn = 1'b0;
    for (int b = COORD_BITS - 1; b >= 0; b--) begin
      refl ^= flip;
      if (op == CMD_ENCODE) begin
        s = {x[b], y[b]} ^ refl;
        if (turn) s = {s[0], s[1]};
        p = {s[1], s[1] ^ s[0]};
        r.key[2*b +: 2] = p;
      end else begin
        p = k[2*b +: 2];
        s = {p[1], p[1] ^ p[0]};
        if (turn) s = {s[0], s[1]};
        a = refl ^ s;
        r.px[b] = a[1];
        r.py[b] = a[0];
      end
      flip = (p == 2'b11) ? 2'b11 : 2'b00;
      turn ^= (p[1] == p[0]);
    end
    return r;
  endfunction

  function automatic logic [31:0] pick_word();
    logic [31:0] w;
    case ($urandom_range(0, 9))
      6: w = '0;
      7: w = '1;
      8: w = 32'h1 << $urandom_range(0, 31);
      9: w = $urandom_range(0, 15);
      default: w = $urandom;
    endcase
    return w;
  endfunction

  task automatic report_mismatch(input string what, input logic [KEY_W-1:0] got,
                                 input logic [KEY_W-1:0] want);
    mismatches++;
    if (printed < 60) begin
      $display("mismatch %0t: %s got %h expected %h", $realtime, what, got, want);
      printed++;
    end
  endtask

  // records accepted beats and checks returned results against the oldest expectation
  always @(posedge clk_i) begin
    map_res_t want;
    if (rst_ni) begin
      if (in_bus.valid && in_bus.ready) begin
        if (cur_fixed) pending_res.push_back(cur_res);
        else pending_res.push_back(hilbert_map(cmd_e'(in_bus.cmd), in_bus.coord_x,
                                               in_bus.coord_y, in_bus.key_in));
      end
      if (out_bus.valid && out_bus.ready) begin
        if (pending_res.size() == 0) begin
          report_mismatch("result with nothing outstanding", out_bus.key_out, '0);
        end else begin
          want = pending_res.pop_front();
          if (out_bus.key_out !== want.key)
            report_mismatch("key_out", out_bus.key_out, want.key);
          if (out_bus.point_x !== want.px)
            report_mismatch("point_x", KEY_W'(out_bus.point_x), KEY_W'(want.px));
          if (out_bus.point_y !== want.py)
            report_mismatch("point_y", KEY_W'(out_bus.point_y), KEY_W'(want.py));
        end
      end
    end
  end

  // result side back-pressure
  always @(negedge clk_i) begin
    if (rst_ni) out_bus.ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 11);
  end

  task automatic send_beat(input stim_row_t row);
    @(negedge clk_i);
    while (!calm && $urandom_range(0, 99) < 11) begin
      in_bus.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_bus.valid   <= 1'b1;
    in_bus.cmd     <= row.op;
    in_bus.coord_x <= row.x;
    in_bus.coord_y <= row.y;
    in_bus.key_in  <= row.k;
    cur_fixed      <= row.fixed;
    cur_res        <= row.res;
    do @(posedge clk_i); while (!in_bus.ready);
  endtask

  initial begin
    stim_row_t row;
    int        guard;
    rst_ni         = 1'b0;
    in_bus.valid   = 1'b0;
    in_bus.cmd     = CMD_ENCODE;
    in_bus.coord_x = '0;
    in_bus.coord_y = '0;
    in_bus.key_in  = '0;
    out_bus.ready  = 1'b0;
    cur_fixed      = 1'b0;
    cur_res        = '0;
    calm           = 1'b0;
    mismatches     = 0;
    printed        = 0;

    // extremes with results known by hand, then rows left to the predictor
    dir_rows.push_back('{CMD_ENCODE, 32'h0, 32'h0, 64'h0, 1'b1, '{64'h0, 32'h0, 32'h0}});
    dir_rows.push_back('{CMD_DECODE, 32'h0, 32'h0, 64'h0, 1'b1, '{64'h0, 32'h0, 32'h0}});
    dir_rows.push_back('{CMD_ENCODE, '1, '1, 64'h0, 1'b1,
                         '{64'hAAAA_AAAA_AAAA_AAAA, 32'h0, 32'h0}});
    dir_rows.push_back('{CMD_DECODE, 32'h0, 32'h0, 64'hAAAA_AAAA_AAAA_AAAA, 1'b1,
                         '{64'h0, '1, '1}});
    dir_rows.push_back('{CMD_ENCODE, '1, 32'h0, 64'h0, 1'b1, '{'1, 32'h0, 32'h0}});
    dir_rows.push_back('{CMD_DECODE, 32'h0, 32'h0, '1, 1'b1, '{64'h0, '1, 32'h0}});
    dir_rows.push_back('{CMD_ENCODE, 32'h0, '1, 64'h0, 1'b1,
                         '{64'h5555_5555_5555_5555, 32'h0, 32'h0}});
    dir_rows.push_back('{CMD_DECODE, 32'h0, 32'h0, 64'h5555_5555_5555_5555, 1'b1,
                         '{64'h0, 32'h0, '1}});
    // operands of the other command must be ignored
    dir_rows.push_back('{CMD_ENCODE, 32'h0, 32'h0, '1, 1'b1, '{64'h0, 32'h0, 32'h0}});
    dir_rows.push_back('{CMD_DECODE, '1, '1, 64'h0, 1'b1, '{64'h0, 32'h0, 32'h0}});
    dir_rows.push_back('{CMD_ENCODE, 32'h8000_0000, 32'h0, 64'h0, 1'b0, '0});
    dir_rows.push_back('{CMD_ENCODE, 32'h0, 32'h8000_0000, 64'h0, 1'b0, '0});
    dir_rows.push_back('{CMD_ENCODE, 32'h1, 32'h0, 64'h0, 1'b0, '0});
    dir_rows.push_back('{CMD_ENCODE, 32'h0, 32'h1, 64'h0, 1'b0, '0});
    dir_rows.push_back('{CMD_ENCODE, 32'hAAAA_AAAA, 32'h5555_5555, 64'h0, 1'b0, '0});
    dir_rows.push_back('{CMD_ENCODE, 32'h5555_5555, 32'hAAAA_AAAA, 64'h0, 1'b0, '0});
    dir_rows.push_back('{CMD_ENCODE, 32'h1234_5678, 32'h9ABC_DEF0, 64'h0, 1'b0, '0});
    dir_rows.push_back('{CMD_DECODE, 32'h0, 32'h0, 64'h8000_0000_0000_0000, 1'b0, '0});
    dir_rows.push_back('{CMD_DECODE, 32'h0, 32'h0, 64'hC000_0000_0000_0000, 1'b0, '0});
    dir_rows.push_back('{CMD_DECODE, 32'h0, 32'h0, 64'h1, 1'b0, '0});
    dir_rows.push_back('{CMD_DECODE, 32'h0, 32'h0, 64'h2, 1'b0, '0});
    dir_rows.push_back('{CMD_DECODE, 32'h0, 32'h0, 64'h3, 1'b0, '0});
    dir_rows.push_back('{CMD_DECODE, 32'h0, 32'h0, 64'hDEAD_BEEF_0123_4567, 1'b0, '0});

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i]) send_beat(dir_rows[i]);

    for (int n = 0; n < NUM_RANDOM; n++) begin
      // a long stretch at full rate on both sides
      calm      = (n >= 400 && n < 700);
      row.op    = $urandom_range(0, 1) ? CMD_DECODE : CMD_ENCODE;
      row.x     = pick_word();
      row.y     = pick_word();
      row.k     = {pick_word(), pick_word()};
      row.fixed = 1'b0;
      row.res   = '0;
      send_beat(row);
    end

    @(negedge clk_i);
    in_bus.valid <= 1'b0;
    calm = 1'b0;
    guard = 0;
    while (pending_res.size() != 0 && guard < 10000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (TAIL_CYC) @(posedge clk_i);
    if (pending_res.size() != 0)
      report_mismatch("results never returned", KEY_W'(pending_res.size()), '0);

    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+sv
sv/hce_pkg.sv
sv/hce_in_if.sv
sv/hce_out_if.sv
sv/hce_stage.sv
sv/hilbert_curve_2d_encode_decode_top.sv
sv/hce_checker.sv
bench/hilbert_curve_2d_encode_decode_top_tb.sv
